// ===== design/tpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpc_pkg: shared widths, types and codes of the circumcircle pipeline
// All widths but QW and OW derive from COORD_WIDTH so that every product and sum is exact.
// ----------------------------------------------------------------------------
package tpc_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int CW = COORD_WIDTH;
	// Differences of two coordinates.
	localparam int DW = CW + 1;
	// Orientation determinant D, signed, and |2D|, unsigned.
	localparam int DETW = 2 * DW;
	localparam int DENW = 2 * DW;
	// Squared lengths |u|^2 and |v|^2, unsigned.
	localparam int UUW = 2 * DW - 1;
	// Partial products of a squared length and a difference.
	localparam int PLW = 2 * DW + 1;
	// Centre numerators, signed, and their magnitudes.
	localparam int NW = 3 * DW;
	localparam int NMW = NW - 1;
	// Limbs used to square a numerator magnitude.
	localparam int LW = (NMW + 2) / 3;
	// Sum of squared numerators, padded to an even width, and its root.
	localparam int SQW = 2 * ((2 * NMW + 2) / 2);
	localparam int RTW = SQW / 2;
	// Dividend width of the dividers and quotient bits kept.
	localparam int DVW = RTW;
	localparam int QW = 34;
	localparam int RW = DENW + 1;
	// Output word width.
	localparam int OW = 32;
	// Stage count of the front end.
	localparam int FR_ST = 9;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_COL = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	typedef struct packed {
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		logic                 col;
		logic                 sx;
		logic                 sy;
		logic [NMW-1:0]       nxm;
		logic [NMW-1:0]       nym;
		logic [DENW-1:0]      den;
	} ctx_t;

	typedef struct packed {
		logic [2:0]    ovf;
		logic [2:0]    remnz;
		logic [QW-1:0] qx;
		logic [QW-1:0] qy;
		logic [QW-1:0] qr;
	} quo_t;

endpackage

// ===== design/tpc_if.sv =====
// ----------------------------------------------------------------------------
// tpc_if: valid/ready channels for point triples and circle results
// A beat moves when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface tpc_pts_if import tpc_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] ax;
	logic signed [CW-1:0] ay;
	logic signed [CW-1:0] bx;
	logic signed [CW-1:0] by;
	logic signed [CW-1:0] cx_in;
	logic signed [CW-1:0] cy_in;
	modport source (output valid, ax, ay, bx, by, cx_in, cy_in, input ready);
	modport sink (input valid, ax, ay, bx, by, cx_in, cy_in, output ready);
endinterface

interface tpc_circ_if import tpc_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic signed [OW-1:0] centre_x;
	logic signed [OW-1:0] centre_y;
	logic [OW-1:0]        radius;
	logic [1:0]           status;
	modport source (output valid, centre_x, centre_y, radius, status, input ready);
	modport sink (input valid, centre_x, centre_y, radius, status, output ready);
endinterface

// ===== design/tpc_front.sv =====
// ----------------------------------------------------------------------------
// tpc_front: determinant, centre numerators and sum of squared numerators
// Nine stages; every multiplication is split to at most about 26 x 26 bits.
// ----------------------------------------------------------------------------
module tpc_front import tpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 up_valid,
	input  logic signed [CW-1:0] ax,
	input  logic signed [CW-1:0] ay,
	input  logic signed [CW-1:0] bx,
	input  logic signed [CW-1:0] by,
	input  logic signed [CW-1:0] cx,
	input  logic signed [CW-1:0] cy,
	output logic                 dn_valid,
	output ctx_t                 dn_ctx,
	output logic [SQW-1:0]       s
);

	logic [FR_ST-1:0] v_s;

	logic signed [CW-1:0] ax_sd [1:5];
	logic signed [CW-1:0] ay_sd [1:5];

	logic signed [DW-1:0] ux_s1, uy_s1, vx_s1, vy_s1;
	logic signed [DW-1:0] ux_s2, uy_s2, vx_s2, vy_s2;
	logic signed [DW-1:0] ux_s3, uy_s3, vx_s3, vy_s3;
	logic signed [2*DW-1:0] pxy_s2, pyx_s2, uxx_s2, uyy_s2, vxx_s2, vyy_s2;
	logic signed [DETW-1:0] d_s3, d_s4;
	logic [UUW-1:0] uu_s3, vv_s3;
	logic signed [PLW-1:0] a1_s4, a2_s4, b1_s4, b2_s4, c1_s4, c2_s4, e1_s4, e2_s4;
	logic signed [NW-1:0] nx_s5, ny_s5;
	logic neg_s5, col_s5;
	logic [DENW-1:0] den_s5;
	ctx_t ctx_s6, ctx_s7, ctx_s8, ctx_s9;
	logic [2*LW-1:0] p_s7 [2][6];
	logic [SQW-1:0] sq_s8 [2];
	logic [SQW-1:0] s_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[FR_ST-2:0], up_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_sd[1] <= ax;
			ay_sd[1] <= ay;
			for (int i = 2; i <= 5; i++) begin
				ax_sd[i] <= ax_sd[i-1];
				ay_sd[i] <= ay_sd[i-1];
			end
		end
	end

	// Stages 1 to 3: differences, plain products, determinant and lengths.
	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1 <= DW'(bx) - DW'(ax);
			uy_s1 <= DW'(by) - DW'(ay);
			vx_s1 <= DW'(cx) - DW'(ax);
			vy_s1 <= DW'(cy) - DW'(ay);

			pxy_s2 <= ux_s1 * vy_s1;
			pyx_s2 <= uy_s1 * vx_s1;
			uxx_s2 <= ux_s1 * ux_s1;
			uyy_s2 <= uy_s1 * uy_s1;
			vxx_s2 <= vx_s1 * vx_s1;
			vyy_s2 <= vy_s1 * vy_s1;
			ux_s2 <= ux_s1;
			uy_s2 <= uy_s1;
			vx_s2 <= vx_s1;
			vy_s2 <= vy_s1;

			d_s3 <= pxy_s2 - pyx_s2;
			uu_s3 <= UUW'(uxx_s2 + uyy_s2);
			vv_s3 <= UUW'(vxx_s2 + vyy_s2);
			ux_s3 <= ux_s2;
			uy_s3 <= uy_s2;
			vx_s3 <= vx_s2;
			vy_s3 <= vy_s2;
		end
	end

	// Stages 4 and 5: squared lengths times differences, split in two halves, then numerators and |2D|.
	always_ff @(posedge clk) begin
		if (en) begin
			a1_s4 <= $signed({1'b0, uu_s3[DW-1:0]}) * vy_s3;
			a2_s4 <= PLW'($signed({1'b0, uu_s3[UUW-1:DW]}) * vy_s3);
			b1_s4 <= $signed({1'b0, vv_s3[DW-1:0]}) * uy_s3;
			b2_s4 <= PLW'($signed({1'b0, vv_s3[UUW-1:DW]}) * uy_s3);
			c1_s4 <= $signed({1'b0, vv_s3[DW-1:0]}) * ux_s3;
			c2_s4 <= PLW'($signed({1'b0, vv_s3[UUW-1:DW]}) * ux_s3);
			e1_s4 <= $signed({1'b0, uu_s3[DW-1:0]}) * vx_s3;
			e2_s4 <= PLW'($signed({1'b0, uu_s3[UUW-1:DW]}) * vx_s3);
			d_s4 <= d_s3;

			nx_s5 <= (NW'(a2_s4) <<< DW) + NW'(a1_s4) - (NW'(b2_s4) <<< DW) - NW'(b1_s4);
			ny_s5 <= (NW'(c2_s4) <<< DW) + NW'(c1_s4) - (NW'(e2_s4) <<< DW) - NW'(e1_s4);
			neg_s5 <= d_s4[DETW-1];
			col_s5 <= (d_s4 == '0);
			den_s5 <= DENW'({(d_s4[DETW-1] ? -d_s4 : d_s4), 1'b0});
		end
	end

	// Stage 6: signs folded with the sign of the determinant, magnitudes.
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s6.ax <= ax_sd[5];
			ctx_s6.ay <= ay_sd[5];
			ctx_s6.col <= col_s5;
			ctx_s6.sx <= nx_s5[NW-1] ^ neg_s5;
			ctx_s6.sy <= ny_s5[NW-1] ^ neg_s5;
			ctx_s6.nxm <= NMW'(nx_s5[NW-1] ? -nx_s5 : nx_s5);
			ctx_s6.nym <= NMW'(ny_s5[NW-1] ? -ny_s5 : ny_s5);
			ctx_s6.den <= den_s5;
		end
	end

	// Stages 7 to 9: square both magnitudes by limbs and add.
	always_ff @(posedge clk) begin
		logic [3*LW-1:0] m;
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				m = (l == 0) ? (3*LW)'(ctx_s6.nxm) : (3*LW)'(ctx_s6.nym);
				p_s7[l][0] <= m[LW-1:0] * m[LW-1:0];
				p_s7[l][1] <= m[LW-1:0] * m[2*LW-1:LW];
				p_s7[l][2] <= m[LW-1:0] * m[3*LW-1:2*LW];
				p_s7[l][3] <= m[2*LW-1:LW] * m[2*LW-1:LW];
				p_s7[l][4] <= m[2*LW-1:LW] * m[3*LW-1:2*LW];
				p_s7[l][5] <= m[3*LW-1:2*LW] * m[3*LW-1:2*LW];
			end
			ctx_s7 <= ctx_s6;

			for (int l = 0; l < 2; l++) begin
				sq_s8[l] <= SQW'(p_s7[l][0])
					+ (SQW'(p_s7[l][1]) << (LW + 1))
					+ (SQW'(p_s7[l][2]) << (2*LW + 1))
					+ (SQW'(p_s7[l][3]) << (2*LW))
					+ (SQW'(p_s7[l][4]) << (3*LW + 1))
					+ (SQW'(p_s7[l][5]) << (4*LW));
			end
			ctx_s8 <= ctx_s7;

			s_s9 <= sq_s8[0] + sq_s8[1];
			ctx_s9 <= ctx_s8;
		end
	end

	assign dn_valid = v_s[FR_ST-1];
	assign dn_ctx = ctx_s9;
	assign s = s_s9;

endmodule

// ===== design/tpc_sqrt.sv =====
// ----------------------------------------------------------------------------
// tpc_sqrt: pipelined integer square root, one root bit per stage
// The item context travels alongside so that it leaves with its root.
// ----------------------------------------------------------------------------
module tpc_sqrt import tpc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           up_valid,
	input  ctx_t           up_ctx,
	input  logic [SQW-1:0] s,
	output logic           dn_valid,
	output ctx_t           dn_ctx,
	output logic [RTW-1:0] root
);

	logic [RTW-1:0]  v_s;
	logic [SQW-1:0]  rad_s  [1:RTW];
	logic [RTW+1:0]  rem_s  [1:RTW];
	logic [RTW-1:0]  root_s [1:RTW];
	ctx_t            ctx_s  [1:RTW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[RTW-2:0], up_valid};
		end
	end

	for (genvar k = 1; k <= RTW; k++) begin : g_st
		logic [SQW-1:0] rad_p;
		logic [RTW+1:0] rem_p;
		logic [RTW-1:0] root_p;
		ctx_t           ctx_p;
		logic [RTW+1:0] cand;
		logic [RTW+1:0] trial;

		if (k == 1) begin : g_first
			assign rad_p = s;
			assign rem_p = '0;
			assign root_p = '0;
			assign ctx_p = up_ctx;
		end else begin : g_next
			assign rad_p = rad_s[k-1];
			assign rem_p = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign ctx_p = ctx_s[k-1];
		end

		// The remainder stays below twice the partial root plus one.
		assign cand = {rem_p[RTW-1:0], rad_p[SQW-1 -: 2]};
		assign trial = {root_p, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k] <= rad_p << 2;
				ctx_s[k] <= ctx_p;
				if (cand >= trial) begin
					rem_s[k] <= cand - trial;
					root_s[k] <= {root_p[RTW-2:0], 1'b1};
				end else begin
					rem_s[k] <= cand;
					root_s[k] <= {root_p[RTW-2:0], 1'b0};
				end
			end
		end
	end

	assign dn_valid = v_s[RTW-1];
	assign dn_ctx = ctx_s[RTW];
	assign root = root_s[RTW];

endmodule

// ===== design/tpc_div.sv =====
// ----------------------------------------------------------------------------
// tpc_div: three pipelined restoring dividers sharing one divisor
// Centre x, centre y and radius quotients by |2D|, one bit per stage.
// ----------------------------------------------------------------------------
module tpc_div import tpc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           up_valid,
	input  ctx_t           up_ctx,
	input  logic [RTW-1:0] root,
	output logic           dn_valid,
	output ctx_t           dn_ctx,
	output quo_t           quo
);

	logic [QW:0]     v_s;
	logic [RW-1:0]   rem_s [0:QW][3];
	logic [QW-1:0]   lo_s  [0:QW][3];
	logic [QW-1:0]   q_s   [0:QW][3];
	logic [2:0]      ovf_s [0:QW];
	ctx_t            ctx_s [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[QW-1:0], up_valid};
		end
	end

	// First stage: split each dividend and flag quotients of more than QW bits.
	always_ff @(posedge clk) begin
		logic [DVW-1:0] dvd;
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				case (l)
					0: dvd = DVW'(up_ctx.nxm);
					1: dvd = DVW'(up_ctx.nym);
					default: dvd = root;
				endcase
				rem_s[0][l] <= RW'(dvd[DVW-1:QW]);
				lo_s[0][l] <= dvd[QW-1:0];
				q_s[0][l] <= '0;
				ovf_s[0][l] <= (RW'(dvd[DVW-1:QW]) >= RW'(up_ctx.den));
			end
			ctx_s[0] <= up_ctx;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_st
		always_ff @(posedge clk) begin
			logic [RW-1:0] cand;
			if (en) begin
				for (int l = 0; l < 3; l++) begin
					cand = {rem_s[k-1][l][DENW-1:0], lo_s[k-1][l][QW-1]};
					lo_s[k][l] <= lo_s[k-1][l] << 1;
					if (cand >= RW'(ctx_s[k-1].den)) begin
						rem_s[k][l] <= cand - RW'(ctx_s[k-1].den);
						q_s[k][l] <= {q_s[k-1][l][QW-2:0], 1'b1};
					end else begin
						rem_s[k][l] <= cand;
						q_s[k][l] <= {q_s[k-1][l][QW-2:0], 1'b0};
					end
				end
				ovf_s[k] <= ovf_s[k-1];
				ctx_s[k] <= ctx_s[k-1];
			end
		end
	end

	assign dn_valid = v_s[QW];
	assign dn_ctx = ctx_s[QW];
	assign quo.ovf = ovf_s[QW];
	assign quo.remnz = {rem_s[QW][2] != '0, rem_s[QW][1] != '0, rem_s[QW][0] != '0};
	assign quo.qx = q_s[QW][0];
	assign quo.qy = q_s[QW][1];
	assign quo.qr = q_s[QW][2];

endmodule

// ===== design/three_point_circumcircle.sv =====
// Pipeline: 9 front stages, 75 root stages, 35 divider stages and 1 output
// register lie between an accepted point beat and its circle beat; the root and
// divider pipelines set the depth. Throughput: one beat per cycle unless the output stalls.
// Reset: arst_n clears all valid bits and the output valid at once; data
// registers keep whatever they hold. No clearing pass is needed.
// ----------------------------------------------------------------------------
// three_point_circumcircle: centre and radius of the circle through 3 points
// Exact determinant arithmetic, floor rounding, saturation and status flags.
// ----------------------------------------------------------------------------
module three_point_circumcircle import tpc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	tpc_pts_if.sink    points,
	tpc_circ_if.source circle
);

	localparam int CSW = QW + 3;
	localparam logic signed [CSW-1:0] CMAX = CSW'(2147483647);
	localparam logic signed [CSW-1:0] CMIN = -CMAX - 1;

	// The whole pipeline moves as one: it advances whenever the output
	// register is empty or its beat is taken in this cycle. A stall freezes
	// every stage together, so no beat is dropped or repeated, and bubbles
	// simply travel along with valid low.
	logic en;

	logic fr_valid, sq_valid, dv_valid;
	ctx_t fr_ctx, sq_ctx, dv_ctx;
	logic [SQW-1:0] s;
	logic [RTW-1:0] root;
	quo_t quo;

	logic valid_q;
	logic signed [OW-1:0] cx_q, cy_q;
	logic [OW-1:0] rad_q;
	logic [1:0] status_q;

	assign en = !valid_q || circle.ready;
	assign points.ready = en;

	// Front end: differences, determinant D, numerators and their squares.
	tpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.up_valid (points.valid),
		.ax       (points.ax),
		.ay       (points.ay),
		.bx       (points.bx),
		.by       (points.by),
		.cx       (points.cx_in),
		.cy       (points.cy_in),
		.dn_valid (fr_valid),
		.dn_ctx   (fr_ctx),
		.s        (s)
	);

	// Root of nx^2 + ny^2. The radius is floor(root / |2D|), which equals
	// the floor of the exact radius.
	tpc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.up_valid (fr_valid),
		.up_ctx   (fr_ctx),
		.s        (s),
		.dn_valid (sq_valid),
		.dn_ctx   (sq_ctx),
		.root     (root)
	);

	// Three dividers by |2D| in parallel: both centre offsets and the radius.
	tpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.up_valid (sq_valid),
		.up_ctx   (sq_ctx),
		.root     (root),
		.dn_valid (dv_valid),
		.dn_ctx   (dv_ctx),
		.quo      (quo)
	);

	// Final stage. A negative offset gives floor(-n/d) = -q minus one when
	// the remainder is nonzero. The offset is added to the first point and
	// clamped to the signed output range; a divider overflow means the
	// offset is already beyond any representable centre.
	logic signed [CSW-1:0] qx, qy, rzx, rzy, fx, fy, sumx, sumy;
	logic hix, lox, hiy, loy, rsat;

	always_comb begin
		qx = CSW'(quo.qx);
		qy = CSW'(quo.qy);
		rzx = CSW'(quo.remnz[0]);
		rzy = CSW'(quo.remnz[1]);
		fx = dv_ctx.sx ? (-qx - rzx) : qx;
		fy = dv_ctx.sy ? (-qy - rzy) : qy;
		sumx = fx + CSW'(dv_ctx.ax);
		sumy = fy + CSW'(dv_ctx.ay);
		hix = (!dv_ctx.sx && quo.ovf[0]) || (!quo.ovf[0] && sumx > CMAX);
		lox = (dv_ctx.sx && quo.ovf[0]) || (!quo.ovf[0] && sumx < CMIN);
		hiy = (!dv_ctx.sy && quo.ovf[1]) || (!quo.ovf[1] && sumy > CMAX);
		loy = (dv_ctx.sy && quo.ovf[1]) || (!quo.ovf[1] && sumy < CMIN);
		rsat = quo.ovf[2] || (quo.qr[QW-1:OW] != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dv_ctx.col) begin
				// Collinear or coincident points: no circle exists.
				cx_q <= '0;
				cy_q <= '0;
				rad_q <= '0;
				status_q <= ST_COL;
			end else begin
				cx_q <= hix ? OW'(CMAX) : (lox ? OW'(CMIN) : OW'(sumx));
				cy_q <= hiy ? OW'(CMAX) : (loy ? OW'(CMIN) : OW'(sumy));
				rad_q <= rsat ? '1 : quo.qr[OW-1:0];
				status_q <= (hix || lox || hiy || loy || rsat) ? ST_SAT : ST_OK;
			end
		end
	end

	assign circle.valid = valid_q;
	assign circle.centre_x = cx_q;
	assign circle.centre_y = cy_q;
	assign circle.radius = rad_q;
	assign circle.status = status_q;

endmodule

// ===== design/tpc_checker.sv =====
// ----------------------------------------------------------------------------
// tpc_checker: port-level checks of the circumcircle block
// Bound to the top level; sees only the channel signals.
// ----------------------------------------------------------------------------
module tpc_checker import tpc_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic signed [OW-1:0] centre_x,
	input logic signed [OW-1:0] centre_y,
	input logic [OW-1:0]        radius,
	input logic [1:0]           status
);

	localparam logic signed [OW-1:0] OMAX = OW'(2147483647);
	localparam logic signed [OW-1:0] OMIN = -OMAX - 1;

	// A result beat that is not taken stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat withdrawn while stalled");

	// The input side only stalls when the output side holds a beat back.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled without an output stall");

	// Collinear points give an all-zero circle.
	a_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_COL |-> centre_x == '0 && centre_y == '0 && radius == '0)
		else $error("collinear result with nonzero fields");

	// A saturated result shows at least one clamped field.
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_SAT |-> centre_x == OMAX || centre_x == OMIN
			|| centre_y == OMAX || centre_y == OMIN || radius == '1)
		else $error("saturated status without a clamped field");

endmodule

bind three_point_circumcircle tpc_checker u_tpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (points.ready),
	.out_valid (circle.valid),
	.out_ready (circle.ready),
	.centre_x  (circle.centre_x),
	.centre_y  (circle.centre_y),
	.radius    (circle.radius),
	.status    (circle.status)
);
